// ----- rtl/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants for the special-leaf prime sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

	// table and sieve sizes
	localparam int TABLE_DEPTH = 2048;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int SIEVE_DEPTH = 1048576;
	localparam int SIEVE_AW    = $clog2(SIEVE_DEPTH);

	// operand widths
	localparam int X_W   = 41;
	localparam int Y_W   = 11;
	localparam int C_W   = 4;
	localparam int P_W   = 12;
	localparam int DEN_W = P_W + Y_W;
	localparam int SUM_W = 64;

	// operation codes
	typedef enum logic [1:0] {
		OP_LOAD_PRIME  = 2'd0,
		OP_LOAD_FACTOR = 2'd1,
		OP_COMPUTE     = 2'd2,
		OP_NONE        = 2'd3
	} op_t;

	// register indexes
	localparam logic [1:0] REG_UPPER_BOUND = 2'd0;
	localparam logic [1:0] REG_LEAF_LIMIT  = 2'd1;
	localparam logic [1:0] REG_PRESIEVED   = 2'd2;

	// moebius codes
	localparam logic [1:0] MU_ZERO = 2'b00;
	localparam logic [1:0] MU_POS  = 2'b01;
	localparam logic [1:0] MU_NEG2 = 2'b10;
	localparam logic [1:0] MU_NEG  = 2'b11;

	// divider request
	typedef struct packed {
		logic             start;
		logic [X_W-1:0]   num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// divider response
	typedef struct packed {
		logic           done;
		logic [X_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/slp_div.sv -----
// ----------------------------------------------------------------------------
// slp_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_div import slp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(X_W + 1);

	logic [X_W-1:0]   quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             qbit;
	logic [DEN_W-1:0] rem_next;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, quot_q[X_W-1]};
		qbit  = (trial >= {1'b0, req.den});
		if (qbit) begin
			rem_next = DEN_W'(trial - {1'b0, req.den});
		end else begin
			rem_next = trial[DEN_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(X_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
		end else if (run_q) begin
			quot_q <= {quot_q[X_W-2:0], qbit};
			rem_q  <= rem_next;
		end
	end

	assign rsp = {done_q, quot_q};

endmodule

`default_nettype wire

// ----- rtl/special_leaf_prime_sum.sv -----
// ----------------------------------------------------------------------------
// special_leaf_prime_sum
// Special-leaf sum S2: table loads, then one sieve walk per compute command.
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  command   start, busy, operation, entry_index,           in/out
//            prime_or_factor, moebius
//  result    done, leaf_sum, status                         out
//  config    psel, penable, pwrite, paddr, pwdata, prdata,  in/out
//            pready
//
// A load beat writes its table entry and leaves busy low.
// After reset busy stays high while the prime table written
// bits are cleared.
// A compute beat holds busy through the x/y divide, the prime count, the sieve
// fill, the presieve strikes and the walk over primes with the per-m leaf sums;
// its length is set by the one shared divider, the single sieve port and the
// sequencer stepping. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module special_leaf_prime_sum import slp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          operation,
	input  wire logic [TABLE_AW-1:0] entry_index,
	input  wire logic [P_W-1:0]      prime_or_factor,
	input  wire logic signed [1:0]   moebius,
	output logic                     done,
	output logic signed [SUM_W-1:0]  leaf_sum,
	output logic                     status,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic [63:0]              prdata,
	output logic                     pready
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DIV_XY, S_CNT_RD, S_CNT_CHK, S_FILL, S_PRE, S_PRE_WAIT,
		S_PRE_CHK, S_STRIKE, S_WALK, S_WALK_WAIT, S_WALK_CHK, S_DIV_YP,
		S_M_TOP, S_M_WAIT, S_M_CHK, S_M_DIV, S_SUM_RD, S_SUM_ACC,
		S_PROD_LO, S_PROD_HI, S_ACC, S_FIN
	} state_t;

	state_t state_q, ret_q;

	// configuration registers
	logic [X_W-1:0] x_q;
	logic [Y_W-1:0] y_q;
	logic [C_W-1:0] c_q;

	// sequencer registers
	logic [TABLE_AW-1:0] clr_q;
	logic [TABLE_AW:0]   b_q;
	logic [TABLE_AW:0]   pi_q;
	logic [SIEVE_AW:0]   limit_q;
	logic [SIEVE_AW+1:0] k_q;
	logic [P_W:0]        stride_q;
	logic [P_W-1:0]      p_q;
	logic [Y_W-1:0]      qy_q;
	logic [Y_W-1:0]      m_q;
	logic [1:0]          mu_q;
	logic [DEN_W-1:0]    pm_q;
	logic [X_W-1:0]      bound_q;
	logic [SIEVE_AW:0]   cur_q;
	logic [SUM_W-1:0]    usum_q;
	logic [SUM_W-1:0]    prod_q;
	logic [SUM_W-1:0]    run_q;
	logic                done_q;
	logic                status_q;
	logic [SUM_W-1:0]    leaf_q;
	logic                div_start_q;
	logic [X_W-1:0]      div_num_q;
	logic [DEN_W-1:0]    div_den_q;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// memories
	logic [P_W:0]     prime_mem [TABLE_DEPTH];
	logic [P_W+1:0]   factor_mem [TABLE_DEPTH];
	logic             sieve_mem [SIEVE_DEPTH];
	logic [P_W:0]     prime_rd_q;
	logic [P_W+1:0]   factor_rd_q;
	logic             sieve_rd_q;
	logic [TABLE_AW-1:0] prime_ra;
	logic             sieve_we;
	logic             sieve_wd;
	logic [SIEVE_AW-1:0] sieve_wa;

	logic             cmd_acc;
	logic             cfg_wr;
	logic [54:0]      mul_w;
	logic [31:0]      mul_b;
	logic [P_W-1:0]   f_rd;
	logic [1:0]       mu_rd;
	logic             p_ok;
	logic [P_W-1:0]   p_rd;

	assign cmd_acc = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign busy    = (state_q != S_IDLE);
	assign pready  = 1'b1;
	assign f_rd    = factor_rd_q[P_W+1:2];
	assign mu_rd   = factor_rd_q[1:0];

	// unwritten prime entries read as zero
	assign p_ok    = prime_rd_q[P_W];
	assign p_rd    = p_ok ? prime_rd_q[P_W-1:0] : '0;

	assign div_req = {div_start_q, div_num_q, div_den_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= Y_W'(1);
			c_q <= C_W'(2);
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_UPPER_BOUND: x_q <= pwdata[X_W-1:0];
				REG_LEAF_LIMIT:  y_q <= pwdata[Y_W-1:0];
				REG_PRESIEVED:   c_q <= pwdata[C_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[4:3])
			REG_UPPER_BOUND: prdata = 64'(x_q);
			REG_LEAF_LIMIT:  prdata = 64'(y_q);
			REG_PRESIEVED:   prdata = 64'(c_q);
			default:         prdata = '0;
		endcase
	end

	// table writes and reads, prime entries carry a written bit on top
	assign prime_ra = b_q[TABLE_AW-1:0];
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			prime_mem[clr_q] <= '0;
		end else if (cmd_acc && operation == OP_LOAD_PRIME) begin
			prime_mem[entry_index] <= {1'b1, prime_or_factor};
		end
		if (cmd_acc && operation == OP_LOAD_FACTOR) begin
			factor_mem[entry_index] <= {prime_or_factor, moebius};
		end
		prime_rd_q  <= prime_mem[prime_ra];
		factor_rd_q <= factor_mem[m_q];
	end

	// sieve port
	always_comb begin
		sieve_we = 1'b0;
		sieve_wd = 1'b0;
		sieve_wa = k_q[SIEVE_AW-1:0];
		if (state_q == S_FILL && k_q < (SIEVE_AW+2)'(limit_q)) begin
			sieve_we = 1'b1;
			sieve_wd = 1'b1;
		end else if (state_q == S_STRIKE && k_q < (SIEVE_AW+2)'(limit_q)) begin
			sieve_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sieve_we) begin
			sieve_mem[sieve_wa] <= sieve_wd;
		end
		sieve_rd_q <= sieve_mem[cur_q[SIEVE_AW-1:0]];
	end

	// product unit, one half of the unsieved sum at a time
	assign mul_b = (state_q == S_PROD_HI) ? usum_q[63:32] : usum_q[31:0];
	assign mul_w = pm_q * mul_b;

	slp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ret_q       <= S_IDLE;
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TABLE_AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_acc && operation == OP_COMPUTE) begin
						if (y_q == '0) begin
							state_q <= S_FIN;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV_XY;
						end
					end
				end
				S_DIV_XY: begin
					if (div_rsp.done) begin
						if (div_rsp.quot >= X_W'(SIEVE_DEPTH)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_CNT_RD;
						end
					end
				end
				S_CNT_RD:   state_q <= S_CNT_CHK;
				S_CNT_CHK: begin
					if (p_ok && p_rd <= P_W'(y_q) &&
							b_q != (TABLE_AW+1)'(TABLE_DEPTH - 1)) begin
						state_q <= S_CNT_RD;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (!(k_q < (SIEVE_AW+2)'(limit_q))) begin
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					if (b_q > (TABLE_AW+1)'(c_q)) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_PRE_WAIT;
					end
				end
				S_PRE_WAIT: state_q <= S_PRE_CHK;
				S_PRE_CHK: begin
					if (p_rd == '0) begin
						state_q <= S_PRE;
					end else begin
						ret_q   <= S_PRE;
						state_q <= S_STRIKE;
					end
				end
				S_STRIKE: begin
					if (!(k_q < (SIEVE_AW+2)'(limit_q))) begin
						state_q <= ret_q;
					end
				end
				S_WALK: begin
					if (b_q >= pi_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_WALK_WAIT;
					end
				end
				S_WALK_WAIT: state_q <= S_WALK_CHK;
				S_WALK_CHK: begin
					if (p_rd == '0) begin
						state_q <= S_WALK;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV_YP;
					end
				end
				S_DIV_YP: begin
					if (div_rsp.done) begin
						state_q <= S_M_TOP;
					end
				end
				S_M_TOP: begin
					if (m_q > qy_q) begin
						state_q <= S_M_WAIT;
					end else begin
						ret_q   <= S_WALK;
						state_q <= S_STRIKE;
					end
				end
				S_M_WAIT: state_q <= S_M_CHK;
				S_M_CHK: begin
					if (mu_rd == MU_ZERO || !(p_q < f_rd)) begin
						state_q <= S_M_TOP;
					end else begin
						ret_q   <= S_M_CHK;
						state_q <= S_M_DIV;
					end
				end
				S_M_DIV: begin
					if (ret_q != S_M_DIV) begin
						div_start_q <= 1'b1;
						ret_q       <= S_M_DIV;
					end else if (div_rsp.done) begin
						state_q <= S_SUM_RD;
					end
				end
				S_SUM_RD: begin
					if (X_W'(cur_q) <= bound_q && cur_q < limit_q) begin
						state_q <= S_SUM_ACC;
					end else begin
						state_q <= S_PROD_LO;
					end
				end
				S_SUM_ACC:  state_q <= S_SUM_RD;
				S_PROD_LO:  state_q <= S_PROD_HI;
				S_PROD_HI:  state_q <= S_ACC;
				S_ACC:      state_q <= S_M_TOP;
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				run_q     <= '0;
				status_q  <= 1'b1;
				div_num_q <= x_q;
				div_den_q <= DEN_W'(y_q);
			end
			S_DIV_XY: begin
				limit_q <= (SIEVE_AW+1)'(div_rsp.quot[SIEVE_AW-1:0]) + 1'b1;
				b_q     <= (TABLE_AW+1)'(1);
				pi_q    <= '0;
				k_q     <= '0;
			end
			S_CNT_CHK: begin
				if (p_ok && p_rd <= P_W'(y_q)) begin
					pi_q <= pi_q + 1'b1;
				end
				b_q <= b_q + 1'b1;
			end
			S_FILL: begin
				k_q <= k_q + 1'b1;
				b_q <= (TABLE_AW+1)'(1);
			end
			S_PRE_CHK: begin
				k_q      <= (SIEVE_AW+2)'(p_rd);
				stride_q <= (P_W+1)'(p_rd);
				b_q      <= b_q + 1'b1;
			end
			S_STRIKE: begin
				k_q <= k_q + (SIEVE_AW+2)'(stride_q);
			end
			S_WALK_CHK: begin
				p_q       <= p_rd;
				m_q       <= y_q;
				cur_q     <= (SIEVE_AW+1)'(1);
				usum_q    <= '0;
				div_num_q <= X_W'(y_q);
				div_den_q <= DEN_W'(p_rd);
				b_q       <= b_q + 1'b1;
			end
			S_DIV_YP: begin
				qy_q <= div_rsp.quot[Y_W-1:0];
			end
			S_M_TOP: begin
				k_q      <= (SIEVE_AW+2)'(p_q);
				stride_q <= {p_q, 1'b0};
			end
			S_M_CHK: begin
				mu_q      <= mu_rd;
				pm_q      <= p_q * m_q;
				div_num_q <= x_q;
				if (mu_rd == MU_ZERO || !(p_q < f_rd)) begin
					m_q <= m_q - 1'b1;
				end
			end
			S_M_DIV: begin
				div_den_q <= pm_q;
				bound_q   <= div_rsp.quot;
			end
			S_SUM_ACC: begin
				if (sieve_rd_q) begin
					usum_q <= usum_q + SUM_W'(cur_q);
				end
				cur_q <= cur_q + 1'b1;
			end
			S_PROD_LO: begin
				prod_q <= SUM_W'(mul_w);
			end
			S_PROD_HI: begin
				prod_q <= prod_q + {mul_w[31:0], 32'b0};
			end
			S_ACC: begin
				case (mu_q)
					MU_POS:  run_q <= run_q - prod_q;
					MU_NEG:  run_q <= run_q + prod_q;
					MU_NEG2: run_q <= run_q + {prod_q[SUM_W-2:0], 1'b0};
					default: ;
				endcase
				m_q <= m_q - 1'b1;
			end
			S_WALK: begin
				status_q <= 1'b0;
			end
			S_FIN: begin
				leaf_q <= status_q ? '0 : run_q;
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign leaf_sum = leaf_q;
	assign status   = status_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a compute in flight");
	a_status_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (leaf_sum == '0))
		else $error("oversize status with nonzero sum");
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_COMPUTE) |=> busy)
		else $error("compute beat did not raise busy");
`endif

endmodule

`default_nettype wire
